// ===== hdl/nbody_gravity_euler_step_assert.svh =====
// assertion macros for the n-body step block
`ifndef NBODY_GRAVITY_EULER_STEP_ASSERT_SVH
`define NBODY_GRAVITY_EULER_STEP_ASSERT_SVH

// checked on every clock edge outside reset
`define NBGE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define NBGE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/nbge_pkg.sv =====
// shared widths and codes for the n-body step block
`timescale 1ns / 1ps
package nbge_pkg;
	localparam int CNT_W        = 5;
	localparam int IDX_W_OUT    = 4;
	localparam int MASS_W       = 16;
	localparam int DT_W         = 16;
	localparam int WORD_W       = 32;
	localparam int LIMIT_BODIES = 16;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;
endpackage

// ===== hdl/nbge_req_if.sv =====
// request channel: body loads and step commands
`timescale 1ns / 1ps
interface nbge_req_if import nbge_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [IDX_W_OUT-1:0]     body_index;
	logic [MASS_W-1:0]        body_mass_in;
	logic signed [WORD_W-1:0] pos_x_in;
	logic signed [WORD_W-1:0] pos_y_in;
	logic signed [WORD_W-1:0] vel_x_in;
	logic signed [WORD_W-1:0] vel_y_in;
	logic                     fixed_in_place;
	logic [DT_W-1:0]          time_step;

	modport source(output valid, req_type, body_index, body_mass_in, pos_x_in, pos_y_in,
		vel_x_in, vel_y_in, fixed_in_place, time_step, input ready);
	modport sink(input valid, req_type, body_index, body_mass_in, pos_x_in, pos_y_in,
		vel_x_in, vel_y_in, fixed_in_place, time_step, output ready);
endinterface

// ===== hdl/nbge_rsp_if.sv =====
// result channel: one item per body after a step
`timescale 1ns / 1ps
interface nbge_rsp_if import nbge_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [IDX_W_OUT-1:0]     out_index;
	logic signed [WORD_W-1:0] pos_x_out;
	logic signed [WORD_W-1:0] pos_y_out;
	logic signed [WORD_W-1:0] vel_x_out;
	logic signed [WORD_W-1:0] vel_y_out;
	logic signed [WORD_W-1:0] acc_x_out;
	logic signed [WORD_W-1:0] acc_y_out;
	logic                     saturated;
	logic                     last_body;

	modport source(output valid, out_index, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
		acc_x_out, acc_y_out, saturated, last_body, input ready);
	modport sink(input valid, out_index, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
		acc_x_out, acc_y_out, saturated, last_body, output ready);
endinterface

// ===== hdl/nbody_gravity_euler_step.sv =====
// direct-summation 2d gravity with semi-implicit euler update, one shared iterative unit
// A load item is written straight into the body store from idle. A step item walks every
// ordered body pair through one shared shift-add / square-root / restoring-divide unit.
// Per pair it fetches the bodies, forms dx^2+dy^2 by shift-add, takes the root, runs
// four divisions and then scales and accumulates. A coincident pair skips the unit and
// a static body skips its pairs. Results leave through an output register, one body
// after another in index order; a stalled result holds the block. The block takes no
// new item until the last result of a step is in that register.
`timescale 1ns / 1ps
module nbody_gravity_euler_step import nbge_pkg::*; #(
	parameter int MAX_BODIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	nbge_req_if.sink          req,
	nbge_rsp_if.source        rsp
);
	localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int LIM   = (MAX_BODIES < LIMIT_BODIES) ? MAX_BODIES : LIMIT_BODIES;
	localparam int MAG_W = WORD_W + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int D_W   = MAG_W;
	localparam int NUM_W = 64;
	localparam int G_W   = 31;
	localparam int SUM_W = 38;

	typedef struct packed {
		logic [MASS_W-1:0]        mass;
		logic signed [WORD_W-1:0] px;
		logic signed [WORD_W-1:0] py;
		logic signed [WORD_W-1:0] vx;
		logic signed [WORD_W-1:0] vy;
		logic                     fixed;
	} body_t;

	typedef struct packed {
		logic                     ovf;
		logic signed [WORD_W-1:0] val;
	} sat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_A_RDI, S_A_GETI, S_A_RDJ, S_A_GETJ, S_MUL, S_SQRT, S_DIV,
		S_TX, S_TY, S_TADD, S_A_NEXTJ, S_A_DONEI, S_A_NEXTI,
		S_U_RD, S_U_GET, S_U_VX, S_U_VY, S_U_PX, S_U_PY, S_U_EMIT
	} state_t;

	function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
		sat_t r;
		if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
			r.ovf = 1'b0;
			r.val = v[WORD_W-1:0];
		end else begin
			r.ovf = 1'b1;
			r.val = v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] mul_dt(input logic signed [WORD_W-1:0] a,
			input logic [DT_W-1:0] dt);
		logic [WORD_W-1:0]      mag;
		logic [WORD_W+DT_W-1:0] p;
		logic [SUM_W-1:0]       pe;
		mag = a[WORD_W-1] ? (~a + 1'b1) : a;
		p   = mag * dt;
		pe  = {{(SUM_W-WORD_W){1'b0}}, p[WORD_W+DT_W-1:DT_W]};
		return a[WORD_W-1] ? -$signed(pe) : $signed(pe);
	endfunction

	function automatic logic signed [SUM_W-1:0] sx38(input logic signed [WORD_W-1:0] a);
		return {{(SUM_W-WORD_W){a[WORD_W-1]}}, a};
	endfunction

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q, n_q, i_q, j_q;
	logic [DT_W-1:0]          dt_q;
	logic signed [WORD_W-1:0] pix_q, piy_q;
	logic [MAG_W-1:0]         ax_q, ay_q;
	logic                     dxpos_q, dypos_q;
	logic [MASS_W-1:0]        mj_q;
	logic [SQ_W-1:0]          sq_q, mula_q;
	logic [MAG_W-1:0]         mulb_q;
	logic                     mph_q;
	logic [6:0]               it_q;
	logic [D_W-1:0]           root_q, d_q, drem_q;
	logic [D_W+2:0]           rem_q;
	logic [NUM_W-1:0]         num_q, quo_q;
	logic [1:0]               dph_q;
	logic [G_W-1:0]           g_q, ux_q, uy_q;
	logic [2*G_W-1:0]         prod_q;
	logic signed [SUM_W-1:0]  sx_q, sy_q;
	logic                     satb_q;
	logic [MAX_BODIES-1:0]    sat_q, acc_vld_q;
	body_t                    ub_q;
	logic signed [WORD_W-1:0] uax_q, uay_q;

	body_t                    mem_q [MAX_BODIES];
	logic signed [WORD_W-1:0] accx_mem_q [MAX_BODIES];
	logic signed [WORD_W-1:0] accy_mem_q [MAX_BODIES];
	body_t                    rd_q;
	logic signed [WORD_W-1:0] accx_rd_q, accy_rd_q;

	logic                     rsp_valid_q;
	logic [IDX_W_OUT-1:0]     out_index_q;
	logic signed [WORD_W-1:0] pxo_q, pyo_q, vxo_q, vyo_q, axo_q, ayo_q;
	logic                     sato_q, lasto_q;

	logic [IDX_W-1:0]         rd_addr, wr_addr;
	logic                     mem_we, acc_we, acc_clr;
	body_t                    mem_wd;
	logic signed [WORD_W-1:0] accx_wd, accy_wd;
	logic [CNT_W-1:0]         act_n;
	logic                     load_ok;

	logic signed [MAG_W-1:0]  dx, dy;
	logic [D_W+2:0]           rem_sh, trial;
	logic [D_W:0]             dt_sh;
	logic                     qbit;
	logic [NUM_W-1:0]         quo_nx;
	sat_t                     satx, saty, satu;
	logic                     emit_ok;
	logic [G_W:0]             tx;

	assign req.ready = (state_q == S_IDLE);
	assign act_n     = (cnt_q > CNT_W'(LIM)) ? CNT_W'(LIM) : cnt_q;
	assign load_ok   = ({{(32-IDX_W_OUT){1'b0}}, req.body_index} < MAX_BODIES);
	assign rd_addr   = (state_q == S_A_RDJ) ? IDX_W'(j_q) : IDX_W'(i_q);
	assign emit_ok   = !rsp_valid_q || rsp.ready;

	assign dx = $signed({pix_q[WORD_W-1], pix_q}) - $signed({rd_q.px[WORD_W-1], rd_q.px});
	assign dy = $signed({piy_q[WORD_W-1], piy_q}) - $signed({rd_q.py[WORD_W-1], rd_q.py});

	assign rem_sh = {rem_q[D_W:0], sq_q[SQ_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign dt_sh  = {drem_q, num_q[NUM_W-1]};
	assign qbit   = (dt_sh >= {1'b0, d_q});
	assign quo_nx = {quo_q[NUM_W-2:0], qbit};
	assign tx     = prod_q[2*G_W-1 -: (G_W+1)];

	assign satx = sat32(sx_q);
	assign saty = sat32(sy_q);

	always_comb begin
		satu = '0;
		case (state_q)
			S_U_VX:  satu = sat32(sx38(ub_q.vx) + mul_dt(uax_q, dt_q));
			S_U_VY:  satu = sat32(sx38(ub_q.vy) + mul_dt(uay_q, dt_q));
			S_U_PX:  satu = sat32(sx38(ub_q.px) + mul_dt(ub_q.vx, dt_q));
			S_U_PY:  satu = sat32(sx38(ub_q.py) + mul_dt(ub_q.vy, dt_q));
			default: satu = '0;
		endcase
	end

	always_comb begin
		mem_we  = 1'b0;
		acc_we  = 1'b0;
		acc_clr = 1'b0;
		wr_addr = IDX_W'(i_q);
		mem_wd  = ub_q;
		accx_wd = satx.val;
		accy_wd = saty.val;
		if (state_q == S_IDLE && req.valid && req.req_type == REQ_LOAD && load_ok) begin
			mem_we       = 1'b1;
			acc_clr      = 1'b1;
			wr_addr      = IDX_W'(req.body_index);
			mem_wd.mass  = req.body_mass_in;
			mem_wd.px    = req.pos_x_in;
			mem_wd.py    = req.pos_y_in;
			mem_wd.vx    = req.vel_x_in;
			mem_wd.vy    = req.vel_y_in;
			mem_wd.fixed = req.fixed_in_place;
		end else if (state_q == S_U_EMIT && emit_ok) begin
			mem_we = 1'b1;
		end else if (state_q == S_A_DONEI) begin
			acc_we = 1'b1;
		end
	end

	// body and acceleration stores
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= mem_wd;
		end
		if (acc_we) begin
			accx_mem_q[wr_addr] <= accx_wd;
			accy_mem_q[wr_addr] <= accy_wd;
		end
		rd_q      <= mem_q[rd_addr];
		accx_rd_q <= acc_vld_q[rd_addr] ? accx_mem_q[rd_addr] : '0;
		accy_rd_q <= acc_vld_q[rd_addr] ? accy_mem_q[rd_addr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else if (acc_clr) begin
			acc_vld_q[wr_addr] <= 1'b0;
		end else if (acc_we) begin
			acc_vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			it_q        <= '0;
			mph_q       <= 1'b0;
			dph_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cnt_q <= cfg_wdata;
			end
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.req_type == REQ_STEP && act_n != '0) begin
						dt_q    <= req.time_step;
						n_q     <= act_n;
						i_q     <= '0;
						state_q <= S_A_RDI;
					end
				end
				S_A_RDI: state_q <= S_A_GETI;
				S_A_GETI: begin
					pix_q  <= rd_q.px;
					piy_q  <= rd_q.py;
					sx_q   <= '0;
					sy_q   <= '0;
					satb_q <= 1'b0;
					j_q    <= '0;
					state_q <= rd_q.fixed ? S_A_NEXTI : S_A_RDJ;
				end
				S_A_RDJ: state_q <= (j_q == i_q) ? S_A_NEXTJ : S_A_GETJ;
				S_A_GETJ: begin
					ax_q    <= dx[MAG_W-1] ? -dx : dx;
					ay_q    <= dy[MAG_W-1] ? -dy : dy;
					dxpos_q <= !dx[MAG_W-1] && (dx != '0);
					dypos_q <= !dy[MAG_W-1] && (dy != '0);
					mj_q    <= rd_q.mass;
					sq_q    <= '0;
					mula_q  <= {{MAG_W{1'b0}}, (dx[MAG_W-1] ? -dx : dx)};
					mulb_q  <= dx[MAG_W-1] ? -dx : dx;
					mph_q   <= 1'b0;
					it_q    <= '0;
					state_q <= (dx == '0 && dy == '0) ? S_A_NEXTJ : S_MUL;
				end
				S_MUL: begin
					if (mulb_q[0]) begin
						sq_q <= sq_q + mula_q;
					end
					mula_q <= mula_q << 1;
					mulb_q <= mulb_q >> 1;
					it_q   <= it_q + 1'b1;
					if (it_q == 7'(MAG_W - 1)) begin
						it_q <= '0;
						if (!mph_q) begin
							mph_q  <= 1'b1;
							mula_q <= {{MAG_W{1'b0}}, ay_q};
							mulb_q <= ay_q;
						end else begin
							rem_q   <= '0;
							root_q  <= '0;
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					sq_q <= sq_q << 2;
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[D_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[D_W-2:0], 1'b0};
					end
					it_q <= it_q + 1'b1;
					if (it_q == 7'(D_W - 1)) begin
						it_q    <= '0;
						d_q     <= {root_q[D_W-2:0], (rem_sh >= trial)};
						num_q   <= {{(NUM_W-MASS_W-40){1'b0}}, mj_q, 40'b0};
						drem_q  <= '0;
						quo_q   <= '0;
						dph_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					num_q  <= num_q << 1;
					quo_q  <= quo_nx;
					drem_q <= qbit ? D_W'(dt_sh - {1'b0, d_q}) : dt_sh[D_W-1:0];
					it_q   <= it_q + 1'b1;
					if (it_q == 7'(NUM_W - 1)) begin
						it_q   <= '0;
						drem_q <= '0;
						quo_q  <= '0;
						dph_q  <= dph_q + 1'b1;
						case (dph_q)
							2'd0: num_q <= quo_nx;
							2'd1: begin
								if (quo_nx > NUM_W'({G_W{1'b1}})) begin
									g_q    <= {G_W{1'b1}};
									satb_q <= 1'b1;
								end else begin
									g_q <= quo_nx[G_W-1:0];
								end
								num_q <= {{(NUM_W-MAG_W-30){1'b0}}, ax_q, 30'b0};
							end
							2'd2: begin
								ux_q  <= quo_nx[G_W-1:0];
								num_q <= {{(NUM_W-MAG_W-30){1'b0}}, ay_q, 30'b0};
							end
							default: begin
								uy_q    <= quo_nx[G_W-1:0];
								state_q <= S_TX;
							end
						endcase
					end
				end
				S_TX: begin
					prod_q  <= g_q * ux_q;
					state_q <= S_TY;
				end
				S_TY: begin
					sx_q    <= dxpos_q ? sx_q - SUM_W'(tx) : sx_q + SUM_W'(tx);
					prod_q  <= g_q * uy_q;
					state_q <= S_TADD;
				end
				S_TADD: begin
					sy_q    <= dypos_q ? sy_q - SUM_W'(tx) : sy_q + SUM_W'(tx);
					state_q <= S_A_NEXTJ;
				end
				S_A_NEXTJ: begin
					if (j_q + 1'b1 == n_q) begin
						state_q <= S_A_DONEI;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_A_RDJ;
					end
				end
				S_A_DONEI: begin
					sat_q[IDX_W'(i_q)] <= satb_q | satx.ovf | saty.ovf;
					state_q <= S_A_NEXTI;
				end
				S_A_NEXTI: begin
					if (i_q + 1'b1 == n_q) begin
						i_q     <= '0;
						state_q <= S_U_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_A_RDI;
					end
				end
				S_U_RD: state_q <= S_U_GET;
				S_U_GET: begin
					ub_q    <= rd_q;
					uax_q   <= accx_rd_q;
					uay_q   <= accy_rd_q;
					satb_q  <= rd_q.fixed ? 1'b0 : sat_q[IDX_W'(i_q)];
					state_q <= rd_q.fixed ? S_U_EMIT : S_U_VX;
				end
				S_U_VX: begin
					ub_q.vx <= satu.val;
					satb_q  <= satb_q | satu.ovf;
					state_q <= S_U_VY;
				end
				S_U_VY: begin
					ub_q.vy <= satu.val;
					satb_q  <= satb_q | satu.ovf;
					state_q <= S_U_PX;
				end
				S_U_PX: begin
					ub_q.px <= satu.val;
					satb_q  <= satb_q | satu.ovf;
					state_q <= S_U_PY;
				end
				S_U_PY: begin
					ub_q.py <= satu.val;
					satb_q  <= satb_q | satu.ovf;
					state_q <= S_U_EMIT;
				end
				S_U_EMIT: begin
					if (emit_ok) begin
						rsp_valid_q <= 1'b1;
						out_index_q <= i_q[IDX_W_OUT-1:0];
						pxo_q       <= ub_q.px;
						pyo_q       <= ub_q.py;
						vxo_q       <= ub_q.vx;
						vyo_q       <= ub_q.vy;
						axo_q       <= uax_q;
						ayo_q       <= uay_q;
						sato_q      <= satb_q;
						lasto_q     <= (i_q + 1'b1 == n_q);
						i_q         <= i_q + 1'b1;
						state_q     <= (i_q + 1'b1 == n_q) ? S_IDLE : S_U_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_index = out_index_q;
	assign rsp.pos_x_out = pxo_q;
	assign rsp.pos_y_out = pyo_q;
	assign rsp.vel_x_out = vxo_q;
	assign rsp.vel_y_out = vyo_q;
	assign rsp.acc_x_out = axo_q;
	assign rsp.acc_y_out = ayo_q;
	assign rsp.saturated = sato_q;
	assign rsp.last_body = lasto_q;

`include "nbody_gravity_euler_step_assert.svh"

	`NBGE_ASSERT(a_body_in_range, (state_q != S_IDLE) |-> (i_q < n_q), "body counter past count")
	`NBGE_ASSERT(a_no_self_pair, (state_q == S_A_GETJ) |-> (j_q != i_q), "body paired with itself")
	`NBGE_ASSERT(a_div_nonzero, (state_q == S_DIV) |-> (d_q != '0), "divide by zero distance")
	`NBGE_ASSERT_ALWAYS(a_load_idle, (mem_we && acc_clr) |-> (state_q == S_IDLE),
		"load written outside idle")
endmodule

// ===== tb/tb_nbody_gravity_euler_step.sv =====
// self-checking testbench for the n-body gravity step block with a built-in fixed-point predictor
`timescale 1ns / 1ps
module tb_nbody_gravity_euler_step;
	import nbge_pkg::*;

	typedef struct {
		logic [3:0]         idx;
		logic signed [31:0] px, py, vx, vy, ax, ay;
		logic               sat, last;
	} body_report_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	nbge_req_if req();
	nbge_rsp_if rsp();

	nbody_gravity_euler_step #(.MAX_BODIES(16)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp)
	);

	// predictor state
	logic [15:0]        m_mass [16];
	logic signed [31:0] m_px [16], m_py [16], m_vx [16], m_vy [16], m_ax [16], m_ay [16];
	bit                 m_static [16];
	int unsigned        m_count;

	body_report_t reports_due[$];
	int fails;
	int items_sent;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (30) #100_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic signed [31:0] sat32(longint v, inout bit f);
		if (v > 64'sd2147483647) begin
			f = 1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			f = 1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic longint scale_by_dt(longint a, logic [15:0] dt);
		longint mag;
		longint p;
		mag = (a < 0) ? -a : a;
		p = (mag * longint'({48'd0, dt})) >>> 16;
		return (a < 0) ? -p : p;
	endfunction

	function automatic logic [127:0] root_floor(logic [67:0] v);
		logic [127:0] rem;
		logic [127:0] root;
		logic [127:0] trial;
		rem = 0;
		root = 0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | v[2*i +: 2];
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	task automatic predict_gravity_step(logic [15:0] dt);
		int unsigned n;
		bit sat [16];
		longint sx, sy, dx, dy, tx, ty;
		logic [127:0] ax, ay, sum, d, g, ux, uy;
		body_report_t r;
		n = (m_count > 16) ? 16 : m_count;
		for (int i = 0; i < n; i++) begin
			sat[i] = 0;
			if (m_static[i]) continue;
			sx = 0;
			sy = 0;
			for (int j = 0; j < n; j++) begin
				if (j == i) continue;
				dx = longint'(m_px[i]) - longint'(m_px[j]);
				dy = longint'(m_py[i]) - longint'(m_py[j]);
				ax = 128'((dx < 0) ? -dx : dx);
				ay = 128'((dy < 0) ? -dy : dy);
				if (ax == 0 && ay == 0) continue;
				sum = ax * ax + ay * ay;
				d = root_floor(sum[67:0]);
				g = ((128'(m_mass[j])) << 40) / d / d;
				if (g > 128'd2147483647) begin
					g = 128'd2147483647;
					sat[i] = 1;
				end
				ux = (ax << 30) / d;
				uy = (ay << 30) / d;
				tx = longint'((g * ux) >> 30);
				ty = longint'((g * uy) >> 30);
				sx += (dx > 0) ? -tx : tx;
				sy += (dy > 0) ? -ty : ty;
			end
			m_ax[i] = sat32(sx, sat[i]);
			m_ay[i] = sat32(sy, sat[i]);
		end
		for (int i = 0; i < n; i++) begin
			if (!m_static[i]) begin
				m_vx[i] = sat32(longint'(m_vx[i]) + scale_by_dt(m_ax[i], dt), sat[i]);
				m_vy[i] = sat32(longint'(m_vy[i]) + scale_by_dt(m_ay[i], dt), sat[i]);
				m_px[i] = sat32(longint'(m_px[i]) + scale_by_dt(m_vx[i], dt), sat[i]);
				m_py[i] = sat32(longint'(m_py[i]) + scale_by_dt(m_vy[i], dt), sat[i]);
			end
			r.idx = i[3:0];
			r.px = m_px[i];
			r.py = m_py[i];
			r.vx = m_vx[i];
			r.vy = m_vy[i];
			r.ax = m_ax[i];
			r.ay = m_ay[i];
			r.sat = sat[i];
			r.last = (i + 1 == n);
			reports_due = {reports_due, r};
		end
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic send_item(logic kind, logic [3:0] idx, logic [15:0] mass,
			logic [31:0] px, logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
			logic fixed, logic [15:0] dt);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.body_index <= idx;
		req.body_mass_in <= mass;
		req.pos_x_in <= px;
		req.pos_y_in <= py;
		req.vel_x_in <= vx;
		req.vel_y_in <= vy;
		req.fixed_in_place <= fixed;
		req.time_step <= dt;
		do @(posedge clk); while (!req.ready);
		items_sent++;
		if (kind == REQ_LOAD) begin
			m_mass[idx] = mass;
			m_px[idx] = px;
			m_py[idx] = py;
			m_vx[idx] = vx;
			m_vy[idx] = vy;
			m_static[idx] = fixed;
			m_ax[idx] = 0;
			m_ay[idx] = 0;
		end else begin
			predict_gravity_step(dt);
		end
	endtask

	task automatic load_body(logic [3:0] idx, logic [15:0] mass, logic [31:0] px,
			logic [31:0] py, logic [31:0] vx, logic [31:0] vy, logic fixed);
		send_item(REQ_LOAD, idx, mass, px, py, vx, vy, fixed, 16'($urandom));
	endtask

	task automatic step_bodies(logic [15:0] dt);
		send_item(REQ_STEP, 4'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
			$urandom, 1'($urandom), dt);
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		wait (reports_due.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_body_count(logic [4:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_count = 32'(v);
	endtask

	task automatic load_random_body(logic [3:0] idx);
		int mode;
		logic [31:0] px, py, vx, vy;
		logic [3:0] other;
		mode = $urandom_range(0, 99);
		other = 4'($urandom);
		if (mode < 60) begin
			px = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			py = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			vx = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			vy = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		end else if (mode < 85) begin
			px = $urandom;
			py = $urandom;
			vx = $urandom;
			vy = $urandom;
		end else begin
			px = m_px[other];
			py = m_py[other];
			vx = $urandom;
			vy = $urandom;
		end
		load_body(idx, 16'($urandom_range(1, 65535)), px, py, vx, vy,
			$urandom_range(0, 4) == 0);
	endtask

	task automatic test_empty_step();
		set_body_count(5'd0);
		step_bodies(16'hffff);
	endtask

	task automatic test_load_extremes();
		load_body(4'd0, 16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
		load_body(4'd1, 16'h0001, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b0);
		load_body(4'd2, 16'h0100, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0, 1'b0);
		load_body(4'd3, 16'h0200, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'd0, 1'b0);
		load_body(4'd4, 16'h0000, 32'h0003_0000, 32'hfffd_0000, 32'd0, 32'd0, 1'b0);
		load_body(4'd5, 16'hffff, 32'h0000_0001, 32'h0000_0000, 32'd0, 32'd0, 1'b1);
		load_body(4'd6, 16'hffff, 32'h0000_0002, 32'h0000_0000, 32'h0001_0000, 32'd0, 1'b0);
		load_body(4'd7, 16'h8000, 32'hffff_0000, 32'h0000_0000, 32'd0, 32'hffff_0000, 1'b1);
		for (int k = 8; k < 16; k++) load_random_body(k[3:0]);
	endtask

	task automatic test_count_limits();
		set_body_count(5'd31);
		step_bodies(16'hffff);
		set_body_count(5'd16);
		step_bodies(16'h0000);
	endtask

	task automatic test_two_body_orbit();
		set_body_count(5'd2);
		load_body(4'd0, 16'h1000, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 1'b0);
		load_body(4'd1, 16'h1000, 32'hffff_0000, 32'd0, 32'd0, 32'hffff_0000, 1'b0);
		step_bodies(16'h1000);
		step_bodies(16'h1000);
	endtask

	task automatic test_random_phases();
		int len;
		logic [4:0] cnt;
		while (items_sent < 480) begin
			if ($urandom_range(0, 9) < 8) cnt = 5'($urandom_range(0, 5));
			else cnt = 5'($urandom_range(6, 9));
			set_body_count(cnt);
			len = $urandom_range(4, 12);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) < 7) begin
					if (cnt != 0 && $urandom_range(0, 4) != 0)
						load_random_body(4'($urandom_range(0, cnt - 1)));
					else
						load_random_body(4'($urandom));
				end else begin
					step_bodies(16'($urandom));
				end
			end
		end
	endtask

	// result side: random back-pressure
	initial begin
		int r;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		body_report_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (reports_due.size() == 0) begin
				$error("body report with nothing pending, index %0d", rsp.out_index);
				fails++;
			end else begin
				e = reports_due.pop_front();
				if (rsp.out_index !== e.idx) begin
					$error("out_index expected %0d got %0d", e.idx, rsp.out_index);
					fails++;
				end
				if (rsp.pos_x_out !== e.px) begin
					$error("pos_x_out expected %0d got %0d", e.px, rsp.pos_x_out);
					fails++;
				end
				if (rsp.pos_y_out !== e.py) begin
					$error("pos_y_out expected %0d got %0d", e.py, rsp.pos_y_out);
					fails++;
				end
				if (rsp.vel_x_out !== e.vx) begin
					$error("vel_x_out expected %0d got %0d", e.vx, rsp.vel_x_out);
					fails++;
				end
				if (rsp.vel_y_out !== e.vy) begin
					$error("vel_y_out expected %0d got %0d", e.vy, rsp.vel_y_out);
					fails++;
				end
				if (rsp.acc_x_out !== e.ax) begin
					$error("acc_x_out expected %0d got %0d", e.ax, rsp.acc_x_out);
					fails++;
				end
				if (rsp.acc_y_out !== e.ay) begin
					$error("acc_y_out expected %0d got %0d", e.ay, rsp.acc_y_out);
					fails++;
				end
				if (rsp.saturated !== e.sat) begin
					$error("saturated expected %0d got %0d", e.sat, rsp.saturated);
					fails++;
				end
				if (rsp.last_body !== e.last) begin
					$error("last_body expected %0d got %0d", e.last, rsp.last_body);
					fails++;
				end
			end
		end
	end

	initial begin
		fails = 0;
		items_sent = 0;
		m_count = 0;
		for (int k = 0; k < 16; k++) begin
			m_mass[k] = '0;
			m_px[k] = 0;
			m_py[k] = 0;
			m_vx[k] = 0;
			m_vy[k] = 0;
			m_ax[k] = 0;
			m_ay[k] = 0;
			m_static[k] = 1'b0;
		end
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.req_type = REQ_LOAD;
		req.body_index = '0;
		req.body_mass_in = '0;
		req.pos_x_in = '0;
		req.pos_y_in = '0;
		req.vel_x_in = '0;
		req.vel_y_in = '0;
		req.fixed_in_place = 1'b0;
		req.time_step = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_step();
		test_load_extremes();
		test_count_limits();
		test_two_body_orbit();
		test_random_phases();

		wait_idle();
		repeat (200) @(posedge clk);
		if (fails == 0 && reports_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nbge_pkg.sv
hdl/nbge_req_if.sv
hdl/nbge_rsp_if.sv
hdl/nbody_gravity_euler_step.sv
tb/tb_nbody_gravity_euler_step.sv
